// ----- sv/fifo_with_delete_by_value_macros.svh -----
// assertion macros used by the queue datapath
`ifndef FIFO_WITH_DELETE_BY_VALUE_MACROS_SVH
`define FIFO_WITH_DELETE_BY_VALUE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define FWDBV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define FWDBV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/fwdbv_pkg.sv -----
// types and codes shared by the queue controller and datapath
`timescale 1ns / 1ps

package fwdbv_pkg;

  localparam int DATA_W  = 32;
  localparam int COUNT_W = 5;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RD_IDX  = 2'd0,
    RD_NEXT = 2'd1,
    RD_HEAD = 2'd2
  } rd_src_t;

  typedef enum logic {
    WR_APPEND = 1'b0,
    WR_SHIFT  = 1'b1
  } wr_src_t;

  typedef struct packed {
    logic    ld_in;
    logic    wr_en;
    wr_src_t wr_src;
    logic    rd_en;
    rd_src_t rd_src;
    logic    clr_idx;
    logic    inc_idx;
    logic    inc_occ;
    logic    dec_occ;
    logic    st_ld;
    status_t st_code;
    logic    ld_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_remove;
    logic full;
    logic empty;
    logic match;
    logic last;
  } dp_stat_t;

endpackage

// ----- sv/fifo_with_delete_by_value.sv -----
// ordered queue with append and delete-first-match, top level
//
//  channel  | ports                                  | beat taken when
//  ---------+----------------------------------------+--------------------
//  command  | start, busy, in_cmd, in_value          | start && !busy
//  result   | out_valid, out_status, out_count,      | out_valid (1 cycle)
//           | out_front_valid, out_front_value       |
//
// one beat at a time; entries live in a ram with one write and one registered read port
// append, or remove on an empty queue: strobe follows dispatch, head read and head capture
// remove: each entry is read then compared; on a hit each later entry is read then moved down
// busy stays high until the strobe cycle, in which the next command may already be taken
// rst_n clears occupancy and control; ram contents need no clearing; results are never held off
`timescale 1ns / 1ps

module fifo_with_delete_by_value
  import fwdbv_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_cmd,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  output logic [1:0]               out_status,
  output logic [COUNT_W-1:0]       out_count,
  output logic                     out_front_valid,
  output logic signed [DATA_W-1:0] out_front_value
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  fwdbv_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  fwdbv_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_cmd          (in_cmd),
    .in_value        (in_value),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_count       (out_count),
    .out_front_valid (out_front_valid),
    .out_front_value (out_front_value)
  );

endmodule

// ----- sv/fwdbv_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module fwdbv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/fwdbv_dp.sv -----
// queue datapath: entry ram, occupancy, scan index, status and result registers
`timescale 1ns / 1ps
`include "fifo_with_delete_by_value_macros.svh"

module fwdbv_dp
  import fwdbv_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_cmd,
  input  logic signed [DATA_W-1:0] in_value,
  input  ctl_cmd_t                 cmd,
  output dp_stat_t                 stat,
  output logic                     out_valid,
  output logic [1:0]               out_status,
  output logic [COUNT_W-1:0]       out_count,
  output logic                     out_front_valid,
  output logic signed [DATA_W-1:0] out_front_value
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OW = $clog2(DEPTH + 1);
  localparam int IW = OW + 1;
  localparam int CW = (OW > COUNT_W) ? OW : COUNT_W;

  logic                     cmd_r;
  logic [DATA_W-1:0]        val_r;
  logic [OW-1:0]            occ_r;
  logic [AW-1:0]            idx_r;
  status_t                  st_r;
  logic                     out_vld_r;
  status_t                  out_st_r;
  logic [COUNT_W-1:0]       out_cnt_r;
  logic                     out_fv_r;
  logic signed [DATA_W-1:0] out_fval_r;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic [DATA_W-1:0] rdata;
  logic [CW-1:0]     occ_ext;

  always_comb begin
    unique case (cmd.rd_src)
      RD_IDX:  raddr = idx_r;
      RD_NEXT: raddr = idx_r + AW'(1);
      RD_HEAD: raddr = '0;
      default: raddr = '0;
    endcase
  end

  always_comb begin
    we = cmd.wr_en;
    unique case (cmd.wr_src)
      WR_APPEND: begin
        waddr = occ_r[AW-1:0];
        wdata = val_r;
      end
      WR_SHIFT: begin
        waddr = idx_r;
        wdata = rdata;
      end
      default: begin
        waddr = idx_r;
        wdata = rdata;
      end
    endcase
  end

  fwdbv_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign stat.is_remove = (cmd_r == CMD_REMOVE);
  assign stat.full      = (occ_r == OW'(DEPTH));
  assign stat.empty     = (occ_r == '0);
  assign stat.match     = (rdata == val_r);
  assign stat.last      = ((IW'(idx_r) + IW'(1)) >= IW'(occ_r));

  assign occ_ext = CW'(occ_r);

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      cmd_r <= in_cmd;
      val_r <= in_value;
    end
    if (cmd.st_ld) begin
      st_r <= cmd.st_code;
    end
    if (cmd.ld_out) begin
      out_st_r   <= st_r;
      out_cnt_r  <= occ_ext[COUNT_W-1:0];
      out_fv_r   <= !stat.empty;
      out_fval_r <= stat.empty ? '0 : $signed(rdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r     <= '0;
      idx_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= cmd.ld_out;
      if (cmd.inc_occ) begin
        occ_r <= occ_r + OW'(1);
      end else if (cmd.dec_occ) begin
        occ_r <= occ_r - OW'(1);
      end
      if (cmd.clr_idx) begin
        idx_r <= '0;
      end else if (cmd.inc_idx) begin
        idx_r <= idx_r + AW'(1);
      end
    end
  end

  assign out_valid       = out_vld_r;
  assign out_status      = out_st_r;
  assign out_count       = out_cnt_r;
  assign out_front_valid = out_fv_r;
  assign out_front_value = out_fval_r;

  `FWDBV_ASSERT_IMP(a_occ_bound, 1'b1, occ_r <= OW'(DEPTH), "occupancy above depth")
  `FWDBV_ASSERT_IMP(a_inc_not_full, cmd.inc_occ, !stat.full, "append into a full queue")
  `FWDBV_ASSERT_IMP(a_dec_not_empty, cmd.dec_occ, !stat.empty, "remove from an empty queue")
  `FWDBV_ASSERT_NXT(a_single_strobe, out_vld_r, !out_vld_r, "result strobe held two cycles")

endmodule

// ----- sv/fwdbv_ctrl.sv -----
// queue controller: sequences append, search, gap closing and head readback
`timescale 1ns / 1ps

module fwdbv_ctrl
  import fwdbv_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DISP = 8'b0000_0010,
    S_SRD  = 8'b0000_0100,
    S_SCMP = 8'b0000_1000,
    S_SHRD = 8'b0001_0000,
    S_SHWR = 8'b0010_0000,
    S_HRD  = 8'b0100_0000,
    S_HCAP = 8'b1000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.ld_in = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (!stat.is_remove) begin
          cmd.st_ld = 1'b1;
          if (stat.full) begin
            cmd.st_code = ST_FULL;
          end else begin
            cmd.st_code = ST_OK;
            cmd.wr_en   = 1'b1;
            cmd.wr_src  = WR_APPEND;
            cmd.inc_occ = 1'b1;
          end
          state_nxt = S_HRD;
        end else if (stat.empty) begin
          cmd.st_ld   = 1'b1;
          cmd.st_code = ST_EMPTY;
          state_nxt   = S_HRD;
        end else begin
          cmd.clr_idx = 1'b1;
          state_nxt   = S_SRD;
        end
      end
      S_SRD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = RD_IDX;
        state_nxt  = S_SCMP;
      end
      S_SCMP: begin
        if (stat.match) begin
          cmd.st_ld   = 1'b1;
          cmd.st_code = ST_OK;
          state_nxt   = S_SHRD;
        end else if (stat.last) begin
          cmd.st_ld   = 1'b1;
          cmd.st_code = ST_NOTFOUND;
          state_nxt   = S_HRD;
        end else begin
          cmd.inc_idx = 1'b1;
          state_nxt   = S_SRD;
        end
      end
      S_SHRD: begin
        if (stat.last) begin
          cmd.dec_occ = 1'b1;
          state_nxt   = S_HRD;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_NEXT;
          state_nxt  = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_src  = WR_SHIFT;
        cmd.inc_idx = 1'b1;
        state_nxt   = S_SHRD;
      end
      S_HRD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = RD_HEAD;
        state_nxt  = S_HCAP;
      end
      S_HCAP: begin
        cmd.ld_out = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- tb/fifo_with_delete_by_value_tb.sv -----
// self-checking testbench for the ordered queue with append and delete-first-match
`timescale 1ns / 1ps

module fifo_with_delete_by_value_tb
  import fwdbv_pkg::*;
();

  localparam int DEPTH       = 16;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 2 * DEPTH + 8;
  localparam logic signed [DATA_W-1:0] MIN_V = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] MAX_V = 32'sh7fff_ffff;

  typedef struct packed {
    status_t                   status;
    logic [COUNT_W-1:0]        count;
    logic                      front_valid;
    logic signed [DATA_W-1:0]  front_value;
  } result_t;

  typedef struct packed {
    logic                      cmd;
    logic signed [DATA_W-1:0]  value;
    logic                      typed;
    result_t                   want;
  } cmd_row_t;

  localparam result_t NO_CHECK = '0;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     in_cmd = CMD_APPEND;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_valid;
  logic [1:0]               out_status;
  logic [COUNT_W-1:0]       out_count;
  logic                     out_front_valid;
  logic signed [DATA_W-1:0] out_front_value;

  logic signed [DATA_W-1:0] model_entries[$];
  result_t                  pending_results[$];
  result_t                  got_beat;
  int                       errors = 0;
  int                       stall_cycles = 0;
  int                       cmds_sent = 0;
  int                       appends_sent = 0;
  int                       max_fill = 0;
  int                       status_seen[4] = '{0, 0, 0, 0};
  bit                       fill_mode = 1'b1;

  cmd_row_t dir_rows [27] = '{
    '{CMD_REMOVE, 32'sd5,        1'b1, '{ST_EMPTY,    5'd0,  1'b0, 32'sd0}},
    '{CMD_APPEND, MIN_V,         1'b1, '{ST_OK,       5'd1,  1'b1, MIN_V}},
    '{CMD_APPEND, MAX_V,         1'b1, '{ST_OK,       5'd2,  1'b1, MIN_V}},
    '{CMD_REMOVE, 32'sd0,        1'b1, '{ST_NOTFOUND, 5'd2,  1'b1, MIN_V}},
    '{CMD_REMOVE, MIN_V,         1'b1, '{ST_OK,       5'd1,  1'b1, MAX_V}},
    '{CMD_REMOVE, MAX_V,         1'b1, '{ST_OK,       5'd0,  1'b0, 32'sd0}},
    '{CMD_APPEND, 32'sd7,        1'b0, NO_CHECK},
    '{CMD_APPEND, 32'sd3,        1'b0, NO_CHECK},
    '{CMD_APPEND, 32'sd7,        1'b0, NO_CHECK},
    '{CMD_REMOVE, 32'sd7,        1'b0, NO_CHECK},
    '{CMD_APPEND, -32'sd1,       1'b0, NO_CHECK},
    '{CMD_APPEND, 32'sd0,        1'b0, NO_CHECK},
    '{CMD_APPEND, 32'sh5555_5555, 1'b0, NO_CHECK},
    '{CMD_APPEND, 32'shaaaa_aaaa, 1'b0, NO_CHECK},
    '{CMD_APPEND, 32'sd1,        1'b0, NO_CHECK},
    '{CMD_APPEND, MAX_V,         1'b0, NO_CHECK},
    '{CMD_APPEND, MIN_V,         1'b0, NO_CHECK},
    '{CMD_APPEND, 32'sd7,        1'b0, NO_CHECK},
    '{CMD_APPEND, 32'sd9,        1'b0, NO_CHECK},
    '{CMD_APPEND, 32'sd10,       1'b0, NO_CHECK},
    '{CMD_APPEND, 32'sd11,       1'b0, NO_CHECK},
    '{CMD_APPEND, 32'sd12,       1'b0, NO_CHECK},
    '{CMD_APPEND, 32'sd13,       1'b0, NO_CHECK},
    '{CMD_APPEND, 32'sd14,       1'b0, NO_CHECK},
    '{CMD_APPEND, 32'sd99,       1'b1, '{ST_FULL,     5'd16, 1'b1, 32'sd3}},
    '{CMD_REMOVE, 32'sd7,        1'b0, NO_CHECK},
    '{CMD_REMOVE, 32'sd3,        1'b0, NO_CHECK}
  };

  fifo_with_delete_by_value #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_count      (out_count),
    .out_front_valid(out_front_valid),
    .out_front_value(out_front_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic result_t queue_step(input logic cmd, input logic signed [DATA_W-1:0] val);
    result_t r;
    int      hit;
    hit = -1;
    r = '0;
    r.status = ST_OK;
    if (cmd == CMD_APPEND) begin
      if (model_entries.size() >= DEPTH) r.status = ST_FULL;
      else model_entries.push_back(val);
    end else if (model_entries.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      foreach (model_entries[i]) if (hit < 0 && model_entries[i] == val) hit = i;
      if (hit < 0) r.status = ST_NOTFOUND;
      else model_entries.delete(hit);
    end
    r.count = COUNT_W'(model_entries.size());
    r.front_valid = (model_entries.size() != 0);
    if (r.front_valid) r.front_value = model_entries[0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want_v,
                                 input logic [DATA_W-1:0] got_v);
    errors++;
    if (errors <= 40)
      $display("mismatch on %s: expected %h, got %h at %0t", what, want_v, got_v, $time);
  endtask

  task automatic send_cmd(input cmd_row_t row, input int idle_pct);
    result_t r;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    in_cmd   <= row.cmd;
    in_value <= row.value;
    do @(posedge clk); while (busy);
    r = queue_step(row.cmd, row.value);
    if (row.typed) r = row.want;
    pending_results.push_back(r);
    cmds_sent++;
    if (row.cmd == CMD_APPEND) appends_sent++;
    status_seen[r.status]++;
    if (model_entries.size() > max_fill) max_fill = model_entries.size();
  endtask

  task automatic run_random(input int n, input int idle_pct);
    cmd_row_t row;
    int       pick;
    repeat (n) begin
      row = '0;
      if (model_entries.size() == DEPTH && $urandom_range(3) == 0) fill_mode = 1'b0;
      if (model_entries.size() == 0 && $urandom_range(3) == 0) fill_mode = 1'b1;
      if ($urandom_range(39) == 0) fill_mode = !fill_mode;
      row.cmd = ($urandom_range(99) < (fill_mode ? 80 : 25)) ? CMD_APPEND : CMD_REMOVE;
      pick = $urandom_range(99);
      if (row.cmd == CMD_REMOVE && model_entries.size() != 0 && pick < 65)
        row.value = model_entries[$urandom_range(model_entries.size() - 1)];
      else if (pick < 75) row.value = DATA_W'($urandom_range(7)) - 32'sd4;
      else if (pick < 82) row.value = $urandom_range(1) ? MIN_V : MAX_V;
      else row.value = $urandom;
      send_cmd(row, idle_pct);
    end
  endtask

  // result beat check against oldest pending prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", '0, {30'd0, out_status});
      end else begin
        got_beat = pending_results.pop_front();
        if (out_status !== got_beat.status)
          report_mismatch("status", DATA_W'(got_beat.status), DATA_W'(out_status));
        if (out_count !== got_beat.count)
          report_mismatch("count", DATA_W'(got_beat.count), DATA_W'(out_count));
        if (out_front_valid !== got_beat.front_valid)
          report_mismatch("front_valid", DATA_W'(got_beat.front_valid),
                          DATA_W'(out_front_valid));
        if (out_front_value !== got_beat.front_value)
          report_mismatch("front_value", got_beat.front_value, out_front_value);
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               stall_cycles, pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) send_cmd(dir_rows[i], 0);
    run_random(500, 0);
    run_random(500, 61);
    run_random(500, 24);
    run_random(500, 0);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("run covered %0d commands (%0d appends, %0d removes), peak fill %0d of %0d",
             cmds_sent, appends_sent, cmds_sent - appends_sent, max_fill, DEPTH);
    $display("outcomes: ok %0d, full %0d, empty %0d, not found %0d; %0d mismatches",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_NOTFOUND], errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/fwdbv_pkg.sv
sv/fwdbv_ram.sv
sv/fwdbv_dp.sv
sv/fwdbv_ctrl.sv
sv/fifo_with_delete_by_value.sv
tb/fifo_with_delete_by_value_tb.sv
